>>> hdl/itgg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itgg_pkg
// Shared types, constants and the grid shape function of the tile grid block.
// ----------------------------------------------------------------------------
package itgg_pkg;

  localparam int DIM_BITS       = 16;  // image and tile size fields
  localparam int CNT_BITS       = 7;   // tile count, grid columns and rows
  localparam int ID_BITS        = 6;   // tile number field
  localparam int MODE_BITS      = 2;
  localparam int CFG_IDX_BITS   = 2;
  localparam int DIV_CNT_BITS   = 4;   // one quotient bit per step, DIM_BITS steps
  localparam int ROOT_MAX       = 8;   // largest floor root of a count up to 64
  localparam int DEF_MAX_TILES  = 64;
  localparam int DEF_COORD_BITS = 16;

  localparam logic [DIM_BITS-1:0]  RST_IMAGE_WIDTH  = 16'd1920;
  localparam logic [DIM_BITS-1:0]  RST_IMAGE_HEIGHT = 16'd1080;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_VERTICAL   = 2'd0,
    MODE_HORIZONTAL = 2'd1,
    MODE_RECT       = 2'd2,
    MODE_SINGLE     = 2'd3
  } tiling_mode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TILING_MODE  = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV_W,
    ST_DIV_H,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic [CNT_BITS-1:0] cols;
    logic [CNT_BITS-1:0] rows;
  } grid_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_grid;
    logic start_div_w;
    logic start_div_h;
    logic capture_w;
    logic capture_h;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic grid_empty;
    logic div_done;
    logic div_busy;
    logic last_pos;
    logic out_free;
  } dp_status_t;

  // Grid shape for a saturated count. Rectangles use the floor root when the
  // count is a perfect square, else the root rounded up to a power of two.
  function automatic grid_t calc_grid(input tiling_mode_t mode,
                                      input logic [CNT_BITS-1:0] count);
    grid_t g;
    logic [CNT_BITS-1:0] s;
    logic [CNT_BITS-1:0] sq;
    g = '0;
    s = '0;
    for (int i = 1; i <= ROOT_MAX; i++) begin
      if ((i * i) <= int'(count)) begin
        s = CNT_BITS'(i);
      end
    end
    sq = CNT_BITS'(int'(s) * int'(s));
    case (mode)
      MODE_VERTICAL: begin
        g.cols = count;
        g.rows = CNT_BITS'(1);
      end
      MODE_HORIZONTAL: begin
        g.cols = CNT_BITS'(1);
        g.rows = count;
      end
      MODE_RECT: begin
        if (sq == count) begin
          g.cols = s;
          g.rows = s;
        end else if (s <= CNT_BITS'(1)) begin
          g.cols = CNT_BITS'(1);
          g.rows = count;
        end else if (s <= CNT_BITS'(2)) begin
          g.cols = CNT_BITS'(2);
          g.rows = count >> 1;
        end else if (s <= CNT_BITS'(4)) begin
          g.cols = CNT_BITS'(4);
          g.rows = count >> 2;
        end else begin
          g.cols = CNT_BITS'(8);
          g.rows = count >> 3;
        end
      end
      default: begin
        g.cols = CNT_BITS'(1);
        g.rows = CNT_BITS'(1);
      end
    endcase
    return g;
  endfunction

endpackage : itgg_pkg
`default_nettype wire

>>> hdl/itgg_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itgg_in_if
// Request channel: one beat carries the requested tile count.
// ----------------------------------------------------------------------------
interface itgg_in_if import itgg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CNT_BITS-1:0] tile_count;

  modport source (output valid, output tile_count, input ready);
  modport sink   (input valid, input tile_count, output ready);
endinterface : itgg_in_if
`default_nettype wire

>>> hdl/itgg_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itgg_out_if
// Tile channel: one beat carries one tile of the grid.
// ----------------------------------------------------------------------------
interface itgg_out_if import itgg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ID_BITS-1:0]  tile_id;
  logic [DIM_BITS-1:0] origin_x;
  logic [DIM_BITS-1:0] origin_y;
  logic [DIM_BITS-1:0] tile_width;
  logic [DIM_BITS-1:0] tile_height;
  logic                last_tile;

  modport source (output valid, output tile_id, output origin_x, output origin_y,
                  output tile_width, output tile_height, output last_tile,
                  input ready);
  modport sink   (input valid, input tile_id, input origin_x, input origin_y,
                  input tile_width, input tile_height, input last_tile,
                  output ready);
endinterface : itgg_out_if
`default_nettype wire

>>> hdl/image_tile_grid_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// image_tile_grid_generator
// Splits the configured image into a grid of tiles for each requested count.
// ----------------------------------------------------------------------------
// Each beat on in_ch carries a tile count; the block answers with one beat per
// tile on out_ch, in row-major order, each giving the tile number, its origin,
// its size and a flag on the final tile. Counts above MAX_TILES saturate. A
// count of zero gives no tiles, except in single-tile mode, which always gives
// one tile covering the whole image. A request that gives no tiles ends once
// its grid shape settles; otherwise the shared divider gives the tile width
// and then the tile height, one quotient bit per cycle, and the tiles follow
// one per cycle while the sink keeps up. Requests are handled one at a time;
// the next request is taken once the last tile sits in the output register.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 tiling
// mode, 1 image width, 2 image height); write only while no request is open.
// ----------------------------------------------------------------------------
module image_tile_grid_generator import itgg_pkg::*; #(
  parameter int MAX_TILES  = DEF_MAX_TILES,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [DIM_BITS-1:0]     cfg_wdata,
  itgg_in_if.sink                      in_ch,
  itgg_out_if.source                   out_ch
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer: owns the request handshake and issues datapath commands.
  itgg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Datapath: configuration, grid, divider, tile walk and output register.
  itgg_datapath #(
    .MAX_TILES  (MAX_TILES),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .count_i   (in_ch.tile_count),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_ch    (out_ch)
  );

  // A request beat closes the request window for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request taken while the previous one was still open");

  // The divider is idle whenever a request is taken.
  a_div_idle_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> !status.div_busy)
    else $error("divider busy at request beat");

  // A tile beat that is not the last one is followed by the next tile at once.
  a_tiles_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last_tile) |=> out_ch.valid)
    else $error("gap in tile stream before the last tile");

  // The tile walk ends with the tile that carries the last tile flag.
  a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && status.last_pos) |=> !cmd.emit)
    else $error("tile walk continued past the last tile");

endmodule : image_tile_grid_generator
`default_nettype wire

>>> hdl/itgg_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itgg_div
// Restoring divider: image size by grid count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module itgg_div import itgg_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start_i,
  input  wire logic [DIM_BITS-1:0] dividend_i,
  input  wire logic [CNT_BITS-1:0] divisor_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [DIM_BITS-1:0]      quotient_o
);

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [DIM_BITS-1:0]     dvd_r, dvd_nxt;   // dividend shifts out, quotient in
  logic [CNT_BITS-1:0]     rem_r, rem_nxt;
  logic [CNT_BITS-1:0]     dsr_r, dsr_nxt;
  logic [CNT_BITS:0]       rem_shift;
  logic [CNT_BITS:0]       rem_diff;
  logic                    qbit;

  assign rem_shift = {rem_r, dvd_r[DIM_BITS-1]};
  assign rem_diff  = rem_shift - {1'b0, dsr_r};
  assign qbit      = (rem_shift >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_BITS'(DIM_BITS - 1);
      dvd_nxt  = dividend_i;
      rem_nxt  = '0;
      dsr_nxt  = divisor_i;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DIM_BITS-2:0], qbit};
      rem_nxt = qbit ? rem_diff[CNT_BITS-1:0] : rem_shift[CNT_BITS-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - DIV_CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy_o     = busy_r;
  assign done_o     = done_r;
  assign quotient_o = dvd_r;

endmodule : itgg_div
`default_nettype wire

>>> hdl/itgg_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itgg_datapath
// Configuration, grid shape, tile size division and tile walk with the
// output register.
// ----------------------------------------------------------------------------
module itgg_datapath import itgg_pkg::*; #(
  parameter int MAX_TILES  = DEF_MAX_TILES,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [DIM_BITS-1:0]     cfg_wdata,
  input  wire logic [CNT_BITS-1:0]     count_i,
  input  wire ctrl_cmd_t               cmd_i,
  output dp_status_t                   status_o,
  itgg_out_if.source                   out_ch
);

  tiling_mode_t        mode_r;
  logic [DIM_BITS-1:0] image_width_r;
  logic [DIM_BITS-1:0] image_height_r;

  logic [CNT_BITS-1:0]   cols_r, rows_r;
  logic [CNT_BITS-1:0]   cx_r, ry_r;
  logic [ID_BITS-1:0]    n_r;
  logic [DIM_BITS-1:0]   cell_w_r, cell_h_r;
  logic [COORD_BITS-1:0] ox_r, oy_r;

  logic                out_valid_r;
  logic [ID_BITS-1:0]  out_id_r;
  logic [DIM_BITS-1:0] out_ox_r, out_oy_r, out_w_r, out_h_r;
  logic                out_last_r;

  logic [CNT_BITS-1:0] count_sat;
  grid_t               grid;
  logic                div_start, div_busy, div_done;
  logic [DIM_BITS-1:0] div_dividend, div_quot;
  logic [CNT_BITS-1:0] div_divisor;
  logic                col_end, row_end;

  logic [COORD_BITS+DIM_BITS-1:0] cw_ext, ch_ext;
  logic [COORD_BITS+DIM_BITS-1:0] ox_ext, oy_ext;

  // Configuration writes; bits above a register's width drop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_RECT;
      image_width_r  <= RST_IMAGE_WIDTH;
      image_height_r <= RST_IMAGE_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TILING_MODE:  mode_r         <= tiling_mode_t'(cfg_wdata[MODE_BITS-1:0]);
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: image_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign count_sat = (int'(count_i) > MAX_TILES) ? CNT_BITS'(MAX_TILES) : count_i;
  assign grid      = calc_grid(mode_r, count_sat);

  assign div_start    = cmd_i.start_div_w | cmd_i.start_div_h;
  assign div_dividend = cmd_i.start_div_h ? image_height_r : image_width_r;
  assign div_divisor  = cmd_i.start_div_h ? rows_r : cols_r;

  itgg_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign col_end = (cx_r == cols_r - CNT_BITS'(1));
  assign row_end = (ry_r == rows_r - CNT_BITS'(1));

  assign cw_ext = {{COORD_BITS{1'b0}}, cell_w_r};
  assign ch_ext = {{COORD_BITS{1'b0}}, cell_h_r};
  assign ox_ext = {{DIM_BITS{1'b0}}, ox_r};
  assign oy_ext = {{DIM_BITS{1'b0}}, oy_r};

  always_ff @(posedge clk) begin
    if (cmd_i.load_grid) begin
      cols_r <= grid.cols;
      rows_r <= grid.rows;
      cx_r   <= '0;
      ry_r   <= '0;
      n_r    <= '0;
      ox_r   <= '0;
      oy_r   <= '0;
    end else if (cmd_i.emit) begin
      n_r <= n_r + ID_BITS'(1);
      if (col_end) begin
        cx_r <= '0;
        ox_r <= '0;
        ry_r <= ry_r + CNT_BITS'(1);
        oy_r <= oy_r + ch_ext[COORD_BITS-1:0];
      end else begin
        cx_r <= cx_r + CNT_BITS'(1);
        ox_r <= ox_r + cw_ext[COORD_BITS-1:0];
      end
    end
    if (cmd_i.capture_w) cell_w_r <= div_quot;
    if (cmd_i.capture_h) cell_h_r <= div_quot;
  end

  // Output register: load a tile when the slot is empty or being drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd_i.emit) begin
      out_id_r   <= n_r;
      out_ox_r   <= ox_ext[DIM_BITS-1:0];
      out_oy_r   <= oy_ext[DIM_BITS-1:0];
      out_w_r    <= cell_w_r;
      out_h_r    <= cell_h_r;
      out_last_r <= col_end & row_end;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.tile_id     = out_id_r;
  assign out_ch.origin_x    = out_ox_r;
  assign out_ch.origin_y    = out_oy_r;
  assign out_ch.tile_width  = out_w_r;
  assign out_ch.tile_height = out_h_r;
  assign out_ch.last_tile   = out_last_r;

  assign status_o.grid_empty = (cols_r == '0) | (rows_r == '0);
  assign status_o.div_done   = div_done;
  assign status_o.div_busy   = div_busy;
  assign status_o.last_pos   = col_end & row_end;
  assign status_o.out_free   = ~out_valid_r | out_ch.ready;

endmodule : itgg_datapath
`default_nettype wire

>>> hdl/itgg_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itgg_ctrl
// Request sequencer: shape the grid, divide twice, then walk the tiles.
// ----------------------------------------------------------------------------
module itgg_ctrl import itgg_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.load_grid = 1'b1;
          state_nxt       = ST_SETUP;
        end
      end
      ST_SETUP: begin
        // drop requests that give an empty grid
        if (status_i.grid_empty) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd_o.start_div_w = 1'b1;
          state_nxt         = ST_DIV_W;
        end
      end
      ST_DIV_W: begin
        if (status_i.div_done) begin
          cmd_o.capture_w   = 1'b1;
          cmd_o.start_div_h = 1'b1;
          state_nxt         = ST_DIV_H;
        end
      end
      ST_DIV_H: begin
        if (status_i.div_done) begin
          cmd_o.capture_h = 1'b1;
          state_nxt       = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last_pos) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule : itgg_ctrl
`default_nettype wire
